// ===== src/bdr_pkg.sv =====
// Package for the bounded depth reachability block.
// Holds the graph size constants and the control word that the controller sends to the cells.
// No dependencies.
package bdr_pkg;

    localparam int VERTICES = 64;
    localparam int V_CNT    = (VERTICES > 64) ? 64 : VERTICES;
    localparam int V_W      = (V_CNT > 1) ? $clog2(V_CNT) : 1;
    localparam int STEP_W   = $clog2(V_CNT + 1);
    localparam int FIELD_W  = 6;
    localparam int EXT_W    = FIELD_W + 1;

    localparam logic [EXT_W-1:0] V_LIMIT = EXT_W'(V_CNT);

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [V_CNT-1:0]   t_vset;
    typedef logic [V_W-1:0]     t_vidx;
    typedef logic [FIELD_W-1:0] t_field;

    typedef struct packed {
        logic  wr_en;
        t_vidx wr_row;
        t_vidx wr_col;
        logic  fr_load;
    } t_cell_ctl;

endpackage

// ===== src/bdr_cell.sv =====
// One cell of the reachability chain: one adjacency row and one frontier bit.
// ORs its row into the passing accumulator when its vertex is in the frontier.
// Depends on bdr_pkg.
module bdr_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bdr_pkg::t_vidx       i_idx,
    input  bdr_pkg::t_cell_ctl   i_ctl,
    input  bdr_pkg::t_vset       i_frontier,
    input  bdr_pkg::t_vset       i_acc,
    output bdr_pkg::t_vset       o_acc
);

    bdr_pkg::t_vset r_row;
    bdr_pkg::t_vset n_row;
    logic           r_front;
    logic           n_front;
    bdr_pkg::t_vset r_acc;
    bdr_pkg::t_vset n_acc;

    always_comb begin
        n_row = r_row;
        if (i_ctl.wr_en && (i_ctl.wr_row == i_idx)) begin
            n_row[i_ctl.wr_col] = 1'b1;
        end
        n_front = i_ctl.fr_load ? i_frontier[i_idx] : r_front;
        n_acc   = r_front ? (i_acc | r_row) : i_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_front <= 1'b0;
        end else begin
            r_row   <= n_row;
            r_front <= n_front;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== src/bounded_depth_reachability.sv =====
// Bounded depth reachability over a directed graph held in a chain of row cells.
// Top level: transaction control, visited set and level sequencing.
// Depends on bdr_pkg and bdr_cell.
//
// Input channel: i_valid / o_stall with i_func, i_from_vertex, i_to_vertex,
// i_depth_limit. Output channel: o_valid / i_stall with o_reachable.
// An add-edge transaction (i_func 0) sets one adjacency bit and
// returns nothing; a vertex outside the graph leaves the graph unchanged.
// A query transaction returns one o_reachable. Source equal to goal, a vertex
// outside the graph or a zero depth limit answer on the next cycle.
// Otherwise the frontier expands one level per pass: an accumulator word
// walks the chain of VERTICES cells, one cell per cycle. A query expands at
// most i_depth_limit levels, fewer if the goal is hit or the frontier empties.
// One query is in flight at a time; o_stall stays high during the search.
// A finished result waits in the output register while i_stall is high;
// further transactions are then held off only if that register is still full.
// Synchronous reset clears the whole adjacency matrix at once, with no sweep.
module bounded_depth_reachability (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_func,
    input  bdr_pkg::t_field       i_from_vertex,
    input  bdr_pkg::t_field       i_to_vertex,
    input  bdr_pkg::t_field       i_depth_limit,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_reachable
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    logic                        r_state;
    logic                        n_state;
    logic [bdr_pkg::STEP_W-1:0]  r_step;
    logic [bdr_pkg::STEP_W-1:0]  n_step;
    bdr_pkg::t_field             r_level;
    bdr_pkg::t_field             n_level;
    bdr_pkg::t_vset              r_visited;
    bdr_pkg::t_vset              n_visited;
    bdr_pkg::t_vidx              r_dst;
    bdr_pkg::t_vidx              n_dst;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic                        r_reachable;
    logic                        n_reachable;

    bdr_pkg::t_cell_ctl          w_ctl;
    bdr_pkg::t_vset              w_front_bus;
    bdr_pkg::t_vset              w_acc [0:bdr_pkg::V_CNT];
    bdr_pkg::t_vset              w_next;
    bdr_pkg::t_vset              w_vis_next;
    logic                        w_in_acc;
    logic                        w_out_free;
    logic                        w_src_ok;
    logic                        w_dst_ok;
    logic                        w_eval;
    logic                        w_hit;
    logic                        w_stop;

    assign w_acc[0] = '0;

    for (genvar g = 0; g < bdr_pkg::V_CNT; g++) begin : g_cell
        bdr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_idx      (bdr_pkg::V_W'(g)),
            .i_ctl      (w_ctl),
            .i_frontier (w_front_bus),
            .i_acc      (w_acc[g]),
            .o_acc      (w_acc[g+1])
        );
    end

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != ST_IDLE) || !w_out_free;
    assign w_in_acc   = i_valid && !o_stall;
    assign w_src_ok   = {1'b0, i_from_vertex} < bdr_pkg::V_LIMIT;
    assign w_dst_ok   = {1'b0, i_to_vertex} < bdr_pkg::V_LIMIT;

    assign w_next     = w_acc[bdr_pkg::V_CNT] & ~r_visited;
    assign w_vis_next = r_visited | w_next;
    assign w_hit      = w_vis_next[r_dst];
    assign w_eval     = (r_state == ST_SWEEP) && (r_step == bdr_pkg::STEP_W'(bdr_pkg::V_CNT));
    assign w_stop     = w_hit || (w_next == '0) || (r_level == bdr_pkg::FIELD_W'(1));

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_level        = r_level;
        n_visited      = r_visited;
        n_dst          = r_dst;
        n_out_valid    = w_out_free ? 1'b0 : r_out_valid;
        n_reachable    = r_reachable;
        w_front_bus    = '0;
        w_ctl.wr_en    = 1'b0;
        w_ctl.wr_row   = i_from_vertex[bdr_pkg::V_W-1:0];
        w_ctl.wr_col   = i_to_vertex[bdr_pkg::V_W-1:0];
        w_ctl.fr_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    priority if (i_func == bdr_pkg::FUNC_ADD) begin
                        w_ctl.wr_en = w_src_ok && w_dst_ok;
                    end else if (i_from_vertex == i_to_vertex) begin
                        n_out_valid = 1'b1;
                        n_reachable = 1'b1;
                    end else if (!w_src_ok || !w_dst_ok || (i_depth_limit == '0)) begin
                        n_out_valid = 1'b1;
                        n_reachable = 1'b0;
                    end else begin
                        w_front_bus   = bdr_pkg::V_CNT'(1) << i_from_vertex[bdr_pkg::V_W-1:0];
                        w_ctl.fr_load = 1'b1;
                        n_visited     = w_front_bus;
                        n_level       = i_depth_limit;
                        n_dst         = i_to_vertex[bdr_pkg::V_W-1:0];
                        n_step        = '0;
                        n_state       = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                priority if (!w_eval) begin
                    n_step = r_step + bdr_pkg::STEP_W'(1);
                end else if (w_stop) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_reachable = w_hit;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    w_front_bus   = w_next;
                    w_ctl.fr_load = 1'b1;
                    n_visited     = w_vis_next;
                    n_level       = r_level - bdr_pkg::FIELD_W'(1);
                    n_step        = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_level     <= n_level;
        r_visited   <= n_visited;
        r_dst       <= n_dst;
        r_reachable <= n_reachable;
    end

    assign o_valid     = r_out_valid;
    assign o_reachable = r_reachable;

endmodule

// ===== src/bdr_checker.sv =====
// Port-level checks for the bounded depth reachability block, bound to its top level.
// Watches the transaction handshakes and the answers that need no search.
// Depends on bounded_depth_reachability.
module bdr_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_stall,
    input  logic                  i_func,
    input  bdr_pkg::t_field       i_from_vertex,
    input  bdr_pkg::t_field       i_to_vertex,
    input  bdr_pkg::t_field       i_depth_limit,
    input  logic                  o_valid,
    input  logic                  i_stall,
    input  logic                  o_reachable
);

    logic w_in_acc;

    assign w_in_acc = i_valid && !o_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_reachable))
        else $error("stalled result changed");

    a_self_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_func == bdr_pkg::FUNC_QUERY) && (i_from_vertex == i_to_vertex)
        |=> o_valid && o_reachable)
        else $error("query to itself not answered as reachable");

    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_func == bdr_pkg::FUNC_QUERY) && (i_from_vertex != i_to_vertex)
        && (i_depth_limit == '0) |=> o_valid && !o_reachable)
        else $error("zero depth query not answered as unreachable");

    a_add_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_func == bdr_pkg::FUNC_ADD) && !o_valid |=> !o_valid)
        else $error("add-edge transaction produced a result");

endmodule

bind bounded_depth_reachability bdr_checker u_bdr_checker (.*);
